/* hw/rtl/lbo_pkg.sv */
// Shared constants, field layouts and types of the label boundary overlay.
`timescale 1ns / 1ps

package lbo_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ID_BITS_DEF   = 32;
  localparam int MAX_HEIGHT    = 1024;
  localparam int ROW_BITS      = $clog2(MAX_HEIGHT);

  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH    = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ERRORS_SHOWN   = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTOURS_SHOWN = 4'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] ERR_MINOR = 2'h1;
  localparam logic [1:0] ERR_MAJOR = 2'h2;

  localparam int RED_BOOST    = 80;
  localparam int ORANGE_RED   = 200;
  localparam int ORANGE_GREEN = 120;
  localparam int ORANGE_BLUE  = 40;
  localparam int CHAN_MAX     = 255;

  localparam int IN_ID_BITS     = 32;
  localparam int IN_ID_LSB      = 0;
  localparam int IN_HIDDEN      = 32;
  localparam int IN_RED_LSB     = 33;
  localparam int IN_GREEN_LSB   = 41;
  localparam int IN_BLUE_LSB    = 49;
  localparam int IN_ERR_LSB     = 57;
  localparam int IN_TDATA_BITS  = 64;
  localparam int OUT_TDATA_BITS = 24;

  // Stored pixel: cell id in the low ID_BITS bits, then these fields.
  localparam int PIX_TAIL_BITS = 27;
  localparam int OFS_HIDDEN    = 0;
  localparam int OFS_RED       = 1;
  localparam int OFS_GREEN     = 9;
  localparam int OFS_BLUE      = 17;
  localparam int OFS_ERR       = 25;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic below_ok;
    logic errors_shown;
    logic contours_shown;
  } nbr_ctl_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

endpackage

/* hw/rtl/label_boundary_overlay.sv */
// Top level of the label boundary overlay: line buffer, pixel pipeline and output register.
//
// Pixels enter on the s_axis channel in raster order, one word per pixel; tuser
// selects a pixel word or a drain word. Each pixel leaves on the m_axis channel
// one row late, when the pixel below it arrives, so row 0 words give no result.
// After the last pixel of a frame the block waits for drain words, one per pixel
// of the bottom row; a pixel word then is dropped, as is a drain word at any
// other time. tlast marks the final pixel of the frame.
// The block takes one word per cycle while the output is not stalled. A result
// reaches m_axis through the pipeline stage, which is loaded along with the line
// buffer read, and then the output register. The line buffer is one RAM entry
// per column holding the two most recent rows; it is read one column ahead and
// written back as each pixel word passes, and no clearing pass is needed after reset.
// When the receiver stalls, the result waits in the output register and one
// more word can be taken into the pipeline stage before s_axis_tready drops.
// Reset clears the frame position and the registers to a one by one frame with
// both overlays off. Writing the width or height restarts the frame.
// The cfg channel is always ready; write it only while the block is idle.
`timescale 1ns / 1ps

module label_boundary_overlay
  import lbo_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // cell_id[31:0], hidden[32], base_red[40:33], base_green[48:41],
  // base_blue[56:49], error_flags[58:57], zero fill above.
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // opcode
  input  logic                      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  // on_boundary
  output logic                      m_axis_tuser,
  // last_pixel
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data
);

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PIXW = ID_BITS + PIX_TAIL_BITS;
  localparam int WCW  = (CFG_BITS > AW + 1) ? CFG_BITS : AW + 1;

  logic [AW-1:0]       w_last;
  logic [ROW_BITS-1:0] h_last;
  logic                errors_shown;
  logic                contours_shown;

  logic [AW-1:0]       col;
  logic [ROW_BITS-1:0] row;
  logic                draining;

  logic                s1_valid;
  logic                s1_drain;
  logic                s1_emit;
  logic                s1_last;
  logic                s1_left_ok;
  logic                s1_right_ok;
  logic                s1_up_ok;
  logic [AW-1:0]       s1_x;
  logic [AW-1:0]       s1_ra;
  logic [PIXW-1:0]     s1_pix;

  logic                fwd_valid;
  logic [AW-1:0]       fwd_addr;
  logic [2*PIXW-1:0]   fwd_data;

  logic [2*PIXW-1:0]   win;
  logic [PIXW-1:0]     prev_center;

  logic                out_valid;
  rgb_t                out_rgb;
  logic                out_boundary;
  logic                out_last;

  logic                in_fire;
  logic                is_drain;
  logic                take;
  logic                out_free;
  logic                s1_go;
  logic                col_end;
  logic                row_end;
  logic [AW-1:0]       ra;
  logic [PIXW-1:0]     in_pix;
  logic                we;
  logic [2*PIXW-1:0]   wdata;
  logic [2*PIXW-1:0]   rdata;
  logic [2*PIXW-1:0]   rd_fix;
  logic [WCW-1:0]      fw_ext;
  logic [AW-1:0]       w_last_next;
  logic [ROW_BITS-1:0] h_last_next;
  nbr_ctl_t            ctl;
  rgb_t                shade_rgb;
  logic                shade_boundary;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign is_drain  = (s_axis_tuser == OP_DRAIN);
  assign take      = in_fire && (is_drain ? draining : !draining);
  assign out_free  = !out_valid || m_axis_tready;
  assign s1_go     = s1_valid && (!s1_emit || out_free);
  assign s_axis_tready = !s1_valid || s1_go;
  assign col_end   = (col == w_last);
  assign row_end   = (row == h_last);
  assign ra        = col_end ? '0 : AW'(col + 1'b1);
  assign cfg_ready = 1'b1;

  assign in_pix = {s_axis_tdata[IN_ERR_LSB +: 2],
                   s_axis_tdata[IN_BLUE_LSB +: 8],
                   s_axis_tdata[IN_GREEN_LSB +: 8],
                   s_axis_tdata[IN_RED_LSB +: 8],
                   s_axis_tdata[IN_HIDDEN],
                   s_axis_tdata[IN_ID_LSB +: ID_BITS]};

  // Entry layout: newer row in the low half, older row in the high half.
  assign we    = s1_go && !s1_drain;
  assign wdata = {win[PIXW-1:0], s1_pix};

  always_comb begin
    if (we && (s1_ra == s1_x)) begin
      rd_fix = wdata;
    end else if (fwd_valid && (fwd_addr == s1_ra)) begin
      rd_fix = fwd_data;
    end else begin
      rd_fix = rdata;
    end
  end

  always_comb begin
    fw_ext = WCW'(cfg_data);
    if (cfg_data == '0) begin
      w_last_next = '0;
    end else if (fw_ext > WCW'(MAX_WIDTH)) begin
      w_last_next = AW'(MAX_WIDTH - 1);
    end else begin
      w_last_next = AW'(fw_ext - 1'b1);
    end
    if (cfg_data == '0) begin
      h_last_next = '0;
    end else if (cfg_data > CFG_BITS'(MAX_HEIGHT)) begin
      h_last_next = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      h_last_next = ROW_BITS'(cfg_data - 1'b1);
    end
  end

  lbo_ram #(
    .WIDTH (2 * PIXW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_x),
    .wdata (wdata),
    .re    (take),
    .raddr (ra),
    .rdata (rdata)
  );

  assign ctl.left_ok        = s1_left_ok;
  assign ctl.right_ok       = s1_right_ok;
  assign ctl.up_ok          = s1_up_ok;
  assign ctl.below_ok       = !s1_drain;
  assign ctl.errors_shown   = errors_shown;
  assign ctl.contours_shown = contours_shown;

  lbo_shade #(
    .ID_BITS (ID_BITS)
  ) u_shade (
    .center      (win[PIXW-1:0]),
    .up          (win[2*PIXW-1:PIXW]),
    .left        (prev_center),
    .right       (rd_fix[PIXW-1:0]),
    .below       (s1_pix),
    .ctl         (ctl),
    .colour      (shade_rgb),
    .on_boundary (shade_boundary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last         <= '0;
      h_last         <= '0;
      errors_shown   <= 1'b0;
      contours_shown <= 1'b0;
      col            <= '0;
      row            <= '0;
      draining       <= 1'b0;
    end else begin
      if (take) begin
        if (is_drain) begin
          if (col_end) begin
            col      <= '0;
            row      <= '0;
            draining <= 1'b0;
          end else begin
            col <= AW'(col + 1'b1);
          end
        end else begin
          if (col_end) begin
            col <= '0;
            if (row_end) begin
              draining <= 1'b1;
            end else begin
              row <= ROW_BITS'(row + 1'b1);
            end
          end else begin
            col <= AW'(col + 1'b1);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            w_last   <= w_last_next;
            col      <= '0;
            row      <= '0;
            draining <= 1'b0;
          end
          REG_FRAME_HEIGHT: begin
            h_last   <= h_last_next;
            col      <= '0;
            row      <= '0;
            draining <= 1'b0;
          end
          REG_ERRORS_SHOWN: begin
            errors_shown <= cfg_data[0];
          end
          REG_CONTOURS_SHOWN: begin
            contours_shown <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid  <= take;
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      fwd_addr    <= s1_x;
      fwd_data    <= wdata;
      s1_drain    <= is_drain;
      s1_emit     <= is_drain || (row != '0);
      s1_last     <= is_drain && col_end;
      s1_left_ok  <= (col != '0);
      s1_right_ok <= !col_end;
      s1_up_ok    <= is_drain ? (h_last != '0) : (row > ROW_BITS'(1));
      s1_x        <= col;
      s1_ra       <= ra;
      s1_pix      <= in_pix;
    end
    if (s1_go) begin
      win         <= rd_fix;
      prev_center <= win[PIXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_rgb      <= shade_rgb;
      out_boundary <= shade_boundary;
      out_last     <= s1_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_rgb;
  assign m_axis_tuser  = out_boundary;
  assign m_axis_tlast  = out_last;

endmodule

/* hw/rtl/lbo_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lbo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/lbo_shade.sv */
// Colour rules and four-neighbour boundary test for one finished pixel.
`timescale 1ns / 1ps

module lbo_shade
  import lbo_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int PIXW = ID_BITS + PIX_TAIL_BITS
) (
  input  logic [PIXW-1:0] center,
  input  logic [PIXW-1:0] up,
  input  logic [PIXW-1:0] left,
  input  logic [PIXW-1:0] right,
  input  logic [PIXW-1:0] below,
  input  nbr_ctl_t        ctl,
  output rgb_t            colour,
  output logic            on_boundary
);

  function automatic logic differs(input logic [PIXW-1:0] n, input logic [ID_BITS-1:0] cid);
    differs = (n[ID_BITS-1:0] != cid) && !n[ID_BITS+OFS_HIDDEN];
  endfunction

  logic [ID_BITS-1:0] cid;
  logic               hid;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [1:0]         err;
  logic [8:0]         boosted;
  logic               border;

  assign cid   = center[ID_BITS-1:0];
  assign hid   = center[ID_BITS+OFS_HIDDEN];
  assign red   = center[ID_BITS+OFS_RED +: 8];
  assign green = center[ID_BITS+OFS_GREEN +: 8];
  assign blue  = center[ID_BITS+OFS_BLUE +: 8];
  assign err   = center[ID_BITS+OFS_ERR +: 2];

  always_comb begin
    boosted = {1'b0, red} + 9'(RED_BOOST);
    border  = ctl.contours_shown && !hid &&
              ((ctl.left_ok && differs(left, cid)) ||
               (ctl.right_ok && differs(right, cid)) ||
               (ctl.up_ok && differs(up, cid)) ||
               (ctl.below_ok && differs(below, cid)));
    colour.red   = red;
    colour.green = green;
    colour.blue  = blue;
    if (hid) begin
      colour.red   = 8'(CHAN_MAX);
      colour.green = 8'(CHAN_MAX);
      colour.blue  = 8'(CHAN_MAX);
    end else if (border) begin
      colour = '0;
    end else if (ctl.errors_shown && ((err & ERR_MAJOR) != 2'b00)) begin
      colour.red   = boosted[8] ? 8'(CHAN_MAX) : boosted[7:0];
      colour.green = {1'b0, green[7:1]};
      colour.blue  = {1'b0, blue[7:1]};
    end else if (ctl.errors_shown && ((err & ERR_MINOR) != 2'b00)) begin
      colour.red   = 8'(ORANGE_RED);
      colour.green = 8'(ORANGE_GREEN);
      colour.blue  = 8'(ORANGE_BLUE);
    end
    on_boundary = border;
  end

endmodule

/* hw/rtl/lbo_checker.sv */
// Port-level assertions for the label boundary overlay, bound to the top level.
`timescale 1ns / 1ps

module lbo_checker
  import lbo_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      m_axis_tlast
);

  // A contour pixel is always drawn black.
  a_boundary_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("boundary pixel is not black");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // The input side only stalls while a result is held back by the receiver.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while the output register is free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output word changed");

endmodule

bind label_boundary_overlay lbo_checker u_lbo_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/testbench.sv */
// Self-checking testbench for the label boundary overlay: frames in, predicted pixels checked.
`timescale 1ns / 1ps

module testbench;
  import lbo_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [1:0]  err;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        hidden;
    logic [31:0] id;
  } pixel_word_t;

  typedef struct packed {
    logic       last;
    logic       boundary;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } shade_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  label_boundary_overlay u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: line store, frame position and registers.
  pixel_word_t line_store [2*MAX_WIDTH_DEF];
  logic [CFG_BITS-1:0] width_reg = 11'd1;
  logic [CFG_BITS-1:0] height_reg = 11'd1;
  logic show_errors = 1'b0;
  logic show_contours = 1'b0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned emitted_pixels = 0;
  bit in_drain = 1'b0;

  shade_t shade_queue[$];
  logic [31:0] frame_ids[$];
  int useful_words = 0;
  int mismatches = 0;
  int burst_left = 0;

  function automatic int unsigned frame_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned frame_rows();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned store_slot(int unsigned row, int unsigned x);
    return (row % 2) * MAX_WIDTH_DEF + x;
  endfunction

  function automatic bit marks_edge(pixel_word_t nbr, logic [31:0] own_id);
    return nbr.id != own_id && !nbr.hidden;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    emitted_pixels = 0;
    in_drain = 1'b0;
  endfunction

  function automatic shade_t shade_pixel(int unsigned x, int unsigned row, bit has_below,
                                         pixel_word_t below);
    shade_t s;
    pixel_word_t p;
    int unsigned w;
    int unsigned red_sum;
    bit boundary;
    w = frame_cols();
    p = line_store[store_slot(row, x)];
    s.red = p.red;
    s.green = p.green;
    s.blue = p.blue;
    boundary = 1'b0;
    if (p.hidden) begin
      s.red = 8'(CHAN_MAX);
      s.green = 8'(CHAN_MAX);
      s.blue = 8'(CHAN_MAX);
    end else begin
      if (show_errors) begin
        if ((p.err & ERR_MAJOR) != 0) begin
          red_sum = p.red + RED_BOOST;
          s.red = (red_sum > CHAN_MAX) ? 8'(CHAN_MAX) : 8'(red_sum);
          s.green = p.green >> 1;
          s.blue = p.blue >> 1;
        end else if ((p.err & ERR_MINOR) != 0) begin
          s.red = 8'(ORANGE_RED);
          s.green = 8'(ORANGE_GREEN);
          s.blue = 8'(ORANGE_BLUE);
        end
      end
      if (show_contours) begin
        if (x > 0 && marks_edge(line_store[store_slot(row, x - 1)], p.id)) boundary = 1'b1;
        if (x + 1 < w && marks_edge(line_store[store_slot(row, x + 1)], p.id)) boundary = 1'b1;
        if (row > 0 && marks_edge(line_store[store_slot(row - 1, x)], p.id)) boundary = 1'b1;
        if (has_below && marks_edge(below, p.id)) boundary = 1'b1;
        if (boundary) begin
          s.red = 8'd0;
          s.green = 8'd0;
          s.blue = 8'd0;
        end
      end
    end
    s.boundary = boundary;
    s.last = (emitted_pixels == w * frame_rows() - 1);
    emitted_pixels++;
    return s;
  endfunction

  // Advances the shadow by one accepted word and queues the pixel it finishes.
  function automatic void take_word(logic op, pixel_word_t px);
    int unsigned w;
    int unsigned h;
    w = frame_cols();
    h = frame_rows();
    if (op == OP_DRAIN) begin
      if (!in_drain) return;
      useful_words++;
      shade_queue.push_back(shade_pixel(col_pos, h - 1, 1'b0, px));
      col_pos++;
      if (col_pos >= w) restart_frame();
      return;
    end
    if (in_drain) return;
    useful_words++;
    if (row_pos > 0) shade_queue.push_back(shade_pixel(col_pos, row_pos - 1, 1'b1, px));
    line_store[store_slot(row_pos, col_pos)] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) in_drain = 1'b1;
      else row_pos++;
    end
  endfunction

  function automatic pixel_word_t mk_pixel(logic [31:0] id, logic hidden, logic [7:0] red,
                                           logic [7:0] green, logic [7:0] blue,
                                           logic [1:0] err);
    pixel_word_t p;
    p.id = id;
    p.hidden = hidden;
    p.red = red;
    p.green = green;
    p.blue = blue;
    p.err = err;
    return p;
  endfunction

  function automatic logic [7:0] rand_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic pixel_word_t rand_pixel();
    return mk_pixel(frame_ids[$urandom_range(0, frame_ids.size() - 1)],
                    $urandom_range(0, 4) == 0, rand_channel(), rand_channel(),
                    rand_channel(), 2'($urandom));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
  endtask

  task automatic send_word(logic op, pixel_word_t px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {5'b0, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    take_word(op, px);
    burst_left--;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = value;
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = value;
        restart_frame();
      end
      REG_ERRORS_SHOWN: show_errors = value[0];
      REG_CONTOURS_SHOWN: show_contours = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops sending and waits until every expected pixel is out and the pipeline is empty.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (shade_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One frame of random pixels and its drain words, cut short at word abort_at if that is >= 0.
  task automatic play_frame(int w, int h, int abort_at, bit noisy);
    int idx;
    int total;
    total = w * h;
    frame_ids.delete();
    repeat ($urandom_range(1, 4))
      frame_ids.push_back($urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 3)));
    for (idx = 0; idx < total + w; idx++) begin
      if (idx == abort_at) break;
      if (noisy && $urandom_range(0, 11) == 0)
        send_word(idx < total ? OP_DRAIN : OP_PIXEL, rand_pixel());
      send_word(idx < total ? OP_PIXEL : OP_DRAIN, rand_pixel());
    end
  endtask

  task automatic test_default_frame();
    frame_ids.delete();
    frame_ids.push_back(32'h0000_0000);
    send_word(OP_DRAIN, rand_pixel());
    send_word(OP_PIXEL, mk_pixel(32'h8000_0000, 1'b0, 8'hFF, 8'h00, 8'hFF, ERR_MAJOR));
    send_word(OP_PIXEL, rand_pixel());
    send_word(OP_DRAIN, rand_pixel());
    settle();
  endtask

  task automatic test_error_colours();
    int idx;
    settle();
    write_reg(REG_ERRORS_SHOWN, 11'd1);
    write_reg(REG_FRAME_WIDTH, 11'd6);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    send_word(OP_PIXEL, mk_pixel(32'h0, 1'b1, 8'd10, 8'd20, 8'd30, ERR_MAJOR));
    send_word(OP_PIXEL, mk_pixel(32'h1, 1'b0, 8'd200, 8'd255, 8'd1, ERR_MAJOR));
    send_word(OP_PIXEL, mk_pixel(32'h2, 1'b0, 8'd175, 8'd0, 8'd255, ERR_MAJOR));
    send_word(OP_PIXEL, mk_pixel(32'h3, 1'b0, 8'd0, 8'd0, 8'd0, ERR_MINOR));
    send_word(OP_PIXEL, mk_pixel(32'h4, 1'b0, 8'd255, 8'd255, 8'd255, ERR_MAJOR | ERR_MINOR));
    send_word(OP_PIXEL, mk_pixel(32'hFFFF_FFFF, 1'b0, 8'd99, 8'd98, 8'd97, 2'b00));
    for (idx = 0; idx < 6; idx++) send_word(OP_DRAIN, rand_pixel());
    settle();
  endtask

  task automatic test_contours();
    logic [31:0] ids [9];
    int idx;
    settle();
    write_reg(REG_CONTOURS_SHOWN, 11'd1);
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    ids = '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h8000_0000, 32'h0000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    for (idx = 0; idx < 9; idx++)
      send_word(OP_PIXEL, mk_pixel(ids[idx], idx == 4, rand_channel(), rand_channel(),
                                   rand_channel(), 2'($urandom)));
    for (idx = 0; idx < 3; idx++) send_word(OP_DRAIN, rand_pixel());
    settle();
  endtask

  task automatic test_geometry();
    int idx;
    settle();
    write_reg(REG_FRAME_WIDTH, 11'h000);
    write_reg(REG_FRAME_HEIGHT, 11'h000);
    play_frame(1, 1, -1, 1'b1);
    settle();
    for (idx = 4; idx < 16; idx++) write_reg(CFG_INDEX_BITS'(idx), 11'($urandom));
    play_frame(1, 1, -1, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'h7FF);
    write_reg(REG_FRAME_HEIGHT, 11'd2);
    play_frame(MAX_WIDTH_DEF, 2, -1, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'h7FF);
    play_frame(1, MAX_HEIGHT, -1, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd5);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    play_frame(5, 3, 7, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 11'd5);
    play_frame(5, 3, -1, 1'b0);
    settle();
  endtask

  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int abort_at;
    bit restart_needed;
    start = useful_words;
    w = 1;
    h = 1;
    restart_needed = 1'b1;
    while (useful_words - start < RANDOM_WORDS) begin
      settle();
      if ($urandom_range(0, 3) == 0) write_reg(REG_ERRORS_SHOWN, 11'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(REG_CONTOURS_SHOWN, 11'($urandom));
      if (restart_needed || $urandom_range(0, 1)) begin
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        h = $urandom_range(1, 6);
        write_reg(REG_FRAME_WIDTH, 11'(w));
        write_reg(REG_FRAME_HEIGHT, 11'(h));
      end
      abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h + w - 1) : -1;
      play_frame(w, h, abort_at, $urandom_range(0, 2) == 0);
      restart_needed = (abort_at >= 0);
    end
    settle();
  endtask

  // Receiver: switches at random among always ready, mostly ready, mostly stalled and toggling patterns.
  initial begin
    int mode;
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(50, 400)) begin
        @(negedge clk);
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = ($urandom_range(0, 3) != 0);
          2: m_axis_tready = ($urandom_range(0, 3) == 0);
          default: begin
            if (hold == 0) begin
              m_axis_tready = !m_axis_tready;
              hold = m_axis_tready ? $urandom_range(1, 5) : $urandom_range(1, 20);
            end
            hold--;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    shade_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (shade_queue.size() == 0) begin
        report_mismatch("word with none expected", 32'(m_axis_tdata), 32'h0);
      end else begin
        want = shade_queue.pop_front();
        if (m_axis_tdata[7:0] !== want.red)
          report_mismatch("out_red", 32'(m_axis_tdata[7:0]), 32'(want.red));
        if (m_axis_tdata[15:8] !== want.green)
          report_mismatch("out_green", 32'(m_axis_tdata[15:8]), 32'(want.green));
        if (m_axis_tdata[23:16] !== want.blue)
          report_mismatch("out_blue", 32'(m_axis_tdata[23:16]), 32'(want.blue));
        if (m_axis_tuser !== want.boundary)
          report_mismatch("on_boundary", 32'(m_axis_tuser), 32'(want.boundary));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_pixel", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    #12_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_frame();
    test_error_colours();
    test_contours();
    test_geometry();
    test_random_frames();
    settle();
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
